// ----- src/lzbf_pkg.sv -----
// Shared types and constants of the bit-flag LZ decompressor.
package lzbf_pkg;

  localparam int HIST_DEPTH = 8192;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int OUT_LANES  = 8;
  localparam int LANE_AW    = $clog2(OUT_LANES);
  localparam int CNT_W      = 4;
  localparam int LEN_W      = 9;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [1:0] REFILL_LOW  = 2'd2;
  localparam logic [1:0] REFILL_HIGH = 2'd1;
  localparam logic [1:0] REFILL_NONE = 2'd0;

  localparam logic [1:0] ST_NORMAL    = 2'd0;
  localparam logic [1:0] ST_END       = 2'd1;
  localparam logic [1:0] ST_AFTER_END = 2'd2;

  typedef enum logic [3:0] {
    PH_TOKEN      = 4'd0,
    PH_BIT2       = 4'd1,
    PH_X2         = 4'd2,
    PH_X3         = 4'd3,
    PH_LIT        = 4'd4,
    PH_SHORT_DIST = 4'd5,
    PH_LONG_LO    = 4'd6,
    PH_LONG_HI    = 4'd7,
    PH_EXTRA      = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    CMD_NONE  = 2'd0,
    CMD_LIT   = 2'd1,
    CMD_MATCH = 2'd2
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_IDLE  = 2'd0,
    B_READ  = 2'd1,
    B_WRITE = 2'd2,
    B_FLUSH = 2'd3
  } back_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_byte_0;
    logic [7:0]       out_byte_1;
    logic [7:0]       out_byte_2;
    logic [7:0]       out_byte_3;
    logic [7:0]       out_byte_4;
    logic [7:0]       out_byte_5;
    logic [7:0]       out_byte_6;
    logic [7:0]       out_byte_7;
    logic [CNT_W-1:0] byte_count;
    logic             run_last;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic               restart;
    logic [7:0]         lit;
    logic [HIST_AW-1:0] distance;
    logic [LEN_W-1:0]   len;
    logic [1:0]         status;
  } cmd_t;

endpackage

// ----- src/lz_bitflag_stream_decompressor.sv -----
// Top level of the bit-flag LZ stream decompressor.
// Input channel: one compressed byte per word (in_valid/in_ready, in_data);
// stream_start in a word restarts the decoder and empties the history first.
// Output channel: words of up to eight decompressed bytes (out_valid/out_ready,
// out_data); byte_count gives the filled lanes, run_last marks the last word
// caused by an input byte, and status reports the end code or bytes after it.
// Every input byte yields at least one output word, possibly with no bytes.
// The parser takes one byte per cycle, while the queue has room, into a
// four-entry command queue; the copy engine then takes each command in its
// idle state and emits a word in its flush state, and on a match it reads
// and then writes each copied byte with a flush per output word, set by the
// read-then-write access to the 8 KiB history memory; it takes no new command
// until it is back in its idle state.
// Reset clears all control state; the history needs no clearing pass because
// entries not yet written since reset or restart read as zero.
// When the receiver stalls, the finished word waits in the output register,
// the copy engine halts, and the input keeps flowing until the queue is full.
module lz_bitflag_stream_decompressor (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lzbf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output lzbf_pkg::out_t out_data
);
  import lzbf_pkg::*;

  cmd_t f_cmd, b_cmd;
  logic f_valid, f_ready, b_valid, b_ready;

  lzbf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cmd_valid(f_valid),
    .cmd_ready(f_ready),
    .cmd      (f_cmd)
  );

  lzbf_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_data (f_cmd),
    .rd_valid(b_valid),
    .rd_ready(b_ready),
    .rd_data (b_cmd)
  );

  lzbf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(b_valid),
    .cmd_ready(b_ready),
    .cmd      (b_cmd),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

// ----- src/lzbf_front.sv -----
// Front end: flag word handling and token parsing, one compressed byte per word.
module lzbf_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lzbf_pkg::in_t in_data,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output lzbf_pkg::cmd_t cmd
);
  import lzbf_pkg::*;

  logic [15:0]        flag_word, flag_word_next;
  logic [4:0]         bits_left, bits_left_next;
  logic [1:0]         refill, refill_next;
  phase_t             phase, phase_next;
  logic [LEN_W-1:0]   plen, plen_next;
  logic [7:0]         plo, plo_next;
  logic [HIST_AW-1:0] pdist, pdist_next;
  logic               finished, finished_next;

  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  always_comb begin
    logic [7:0] b;
    logic       v;
    b = in_data.in_byte;
    v = 1'b0;
    if (in_data.stream_start) begin
      flag_word_next = '0;
      bits_left_next = '0;
      refill_next    = REFILL_LOW;
      phase_next     = PH_TOKEN;
      plen_next      = '0;
      plo_next       = '0;
      pdist_next     = '0;
      finished_next  = 1'b0;
    end else begin
      flag_word_next = flag_word;
      bits_left_next = bits_left;
      refill_next    = refill;
      phase_next     = phase;
      plen_next      = plen;
      plo_next       = plo;
      pdist_next     = pdist;
      finished_next  = finished;
    end
    cmd.kind     = CMD_NONE;
    cmd.restart  = in_data.stream_start;
    cmd.lit      = b;
    cmd.distance = pdist_next;
    cmd.len      = plen_next;
    cmd.status   = ST_NORMAL;

    if (finished_next) begin
      cmd.status = ST_AFTER_END;
    end else if (refill_next == REFILL_LOW) begin
      flag_word_next = {8'h00, b};
      refill_next    = REFILL_HIGH;
    end else if (refill_next == REFILL_HIGH) begin
      flag_word_next = {b, flag_word_next[7:0]};
      refill_next    = REFILL_NONE;
      bits_left_next = 5'd16;
    end else begin
      case (phase_next)
        PH_LIT: begin
          cmd.kind   = CMD_LIT;
          phase_next = PH_TOKEN;
        end
        PH_SHORT_DIST: begin
          pdist_next   = {5'd0, 8'hff - b};
          cmd.distance = pdist_next;
          cmd.kind     = CMD_MATCH;
          phase_next   = PH_TOKEN;
        end
        PH_LONG_LO: begin
          plo_next   = b;
          phase_next = PH_LONG_HI;
        end
        PH_LONG_HI: begin
          pdist_next   = 13'h1fff - {b[7:3], plo_next};
          cmd.distance = pdist_next;
          if (b[2:0] != 3'd0) begin
            plen_next  = LEN_W'(b[2:0]) + LEN_W'(2);
            cmd.len    = plen_next;
            cmd.kind   = CMD_MATCH;
            phase_next = PH_TOKEN;
          end else begin
            phase_next = PH_EXTRA;
          end
        end
        PH_EXTRA: begin
          if (b == 8'd0) begin
            finished_next = 1'b1;
            cmd.status    = ST_END;
          end else if (b != 8'd1) begin
            plen_next = LEN_W'(b) + LEN_W'(1);
            cmd.len   = plen_next;
            cmd.kind  = CMD_MATCH;
          end
          phase_next = PH_TOKEN;
        end
        default: phase_next = PH_TOKEN;
      endcase
    end

    // A token needs at most four flag bits before it waits for a byte.
    if (!finished_next) begin
      for (int i = 0; i < 4; i++) begin
        if (refill_next == REFILL_NONE && bits_left_next != 5'd0 &&
            (phase_next == PH_TOKEN || phase_next == PH_BIT2 ||
             phase_next == PH_X2 || phase_next == PH_X3)) begin
          v              = flag_word_next[0];
          flag_word_next = {1'b0, flag_word_next[15:1]};
          bits_left_next = bits_left_next - 5'd1;
          if (bits_left_next == 5'd0) refill_next = REFILL_LOW;
          case (phase_next)
            PH_TOKEN: phase_next = v ? PH_LIT : PH_BIT2;
            PH_BIT2:  phase_next = v ? PH_LONG_LO : PH_X2;
            PH_X2: begin
              plen_next  = {7'd0, v, 1'b0};
              phase_next = PH_X3;
            end
            default: begin
              plen_next  = plen_next + LEN_W'(v) + LEN_W'(2);
              phase_next = PH_SHORT_DIST;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag_word <= '0;
      bits_left <= '0;
      refill    <= REFILL_LOW;
      phase     <= PH_TOKEN;
      plen      <= '0;
      plo       <= '0;
      pdist     <= '0;
      finished  <= 1'b0;
    end else if (in_valid && cmd_ready) begin
      flag_word <= flag_word_next;
      bits_left <= bits_left_next;
      refill    <= refill_next;
      phase     <= phase_next;
      plen      <= plen_next;
      plo       <= plo_next;
      pdist     <= pdist_next;
      finished  <= finished_next;
    end
  end

endmodule

// ----- src/lzbf_fifo.sv -----
// Short command queue between the parser and the copy engine.
module lzbf_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  lzbf_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output lzbf_pkg::cmd_t rd_data
);
  import lzbf_pkg::*;

  cmd_t               entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               push, pop;

  assign wr_ready = (count != (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

// ----- src/lzbf_back.sv -----
// Back end: history memory, match copy and packing of bytes into output words.
module lzbf_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_ready,
  input  lzbf_pkg::cmd_t cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output lzbf_pkg::out_t out_data
);
  import lzbf_pkg::*;

  logic [7:0]         history [HIST_DEPTH];
  back_state_t        state, state_next;
  logic [HIST_AW-1:0] wp, wp_next;
  logic               full, full_next;
  logic [HIST_AW-1:0] src, src_next;
  logic [LEN_W-1:0]   remain, remain_next;
  logic [1:0]         status, status_next;
  logic               last, last_next;
  logic [7:0]         lanes [OUT_LANES];
  logic [7:0]         lanes_next [OUT_LANES];
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               rd_ok, rd_ok_next;
  logic [7:0]         rdata;
  logic               we;
  logic [HIST_AW-1:0] waddr;
  logic [7:0]         wdata;
  logic               out_load;
  logic               can_load;

  assign can_load  = !out_valid || out_ready;
  assign cmd_ready = (state == B_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE: begin
        if (cmd_valid) state_next = (cmd.kind == CMD_MATCH) ? B_READ : B_FLUSH;
      end
      B_READ:  state_next = B_WRITE;
      B_WRITE: begin
        if (remain == LEN_W'(1) || cnt == CNT_W'(OUT_LANES - 1)) state_next = B_FLUSH;
        else state_next = B_READ;
      end
      B_FLUSH: begin
        if (can_load) state_next = last ? B_IDLE : B_READ;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    logic [HIST_AW-1:0] base_wp;
    logic               base_full;
    base_wp     = cmd.restart ? '0 : wp;
    base_full   = cmd.restart ? 1'b0 : full;
    wp_next     = wp;
    full_next   = full;
    src_next    = src;
    remain_next = remain;
    status_next = status;
    last_next   = last;
    lanes_next  = lanes;
    cnt_next    = cnt;
    rd_ok_next  = rd_ok;
    we          = 1'b0;
    waddr       = wp;
    wdata       = rdata;
    out_load    = 1'b0;
    case (state)
      B_IDLE: begin
        if (cmd_valid) begin
          wp_next     = base_wp;
          full_next   = base_full;
          status_next = cmd.status;
          remain_next = cmd.len;
          src_next    = base_wp - HIST_AW'(1) - cmd.distance;
          last_next   = (cmd.kind != CMD_MATCH);
          if (cmd.kind == CMD_LIT) begin
            we            = 1'b1;
            waddr         = base_wp;
            wdata         = cmd.lit;
            lanes_next[0] = cmd.lit;
            cnt_next      = CNT_W'(1);
            wp_next       = base_wp + HIST_AW'(1);
            if (base_wp == HIST_AW'(HIST_DEPTH - 1)) full_next = 1'b1;
          end
        end
      end
      B_READ: begin
        // Entries at or above the write pointer were never written until wrap.
        rd_ok_next = full || (src < wp);
      end
      B_WRITE: begin
        we    = 1'b1;
        waddr = wp;
        wdata = rd_ok ? rdata : 8'd0;
        lanes_next[cnt[LANE_AW-1:0]] = wdata;
        cnt_next    = cnt + CNT_W'(1);
        remain_next = remain - LEN_W'(1);
        src_next    = src + HIST_AW'(1);
        wp_next     = wp + HIST_AW'(1);
        if (wp == HIST_AW'(HIST_DEPTH - 1)) full_next = 1'b1;
        if (remain == LEN_W'(1)) last_next = 1'b1;
      end
      B_FLUSH: begin
        if (can_load) begin
          out_load = 1'b1;
          cnt_next = '0;
          for (int i = 0; i < OUT_LANES; i++) lanes_next[i] = 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) history[waddr] <= wdata;
    rdata <= history[src];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wp        <= '0;
      full      <= 1'b0;
      cnt       <= '0;
      last      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < OUT_LANES; i++) lanes[i] <= 8'd0;
    end else begin
      state <= state_next;
      wp    <= wp_next;
      full  <= full_next;
      cnt   <= cnt_next;
      last  <= last_next;
      lanes <= lanes_next;
      if (out_load)       out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    src    <= src_next;
    remain <= remain_next;
    status <= status_next;
    rd_ok  <= rd_ok_next;
    if (out_load) begin
      out_data.out_byte_0 <= lanes[0];
      out_data.out_byte_1 <= lanes[1];
      out_data.out_byte_2 <= lanes[2];
      out_data.out_byte_3 <= lanes[3];
      out_data.out_byte_4 <= lanes[4];
      out_data.out_byte_5 <= lanes[5];
      out_data.out_byte_6 <= lanes[6];
      out_data.out_byte_7 <= lanes[7];
      out_data.byte_count <= cnt;
      out_data.run_last   <= last;
      out_data.status     <= status;
    end
  end

endmodule
